// ===== design/integer_literal_recognizer_top_macros.svh =====
// Assertion macros for the integer literal recognizer.
// Uses the clk_i and rst_ni names of the module that includes it.
`ifndef INTEGER_LITERAL_RECOGNIZER_TOP_MACROS_SVH
`define INTEGER_LITERAL_RECOGNIZER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ILR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ILR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ILR_ASSERT_IMPL(label, ante, cons, msg)
`define ILR_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== design/ilr_pkg.sv =====
// Types, constants and helper functions for the integer literal recognizer.
// No dependencies.
package ilr_pkg;

  typedef enum logic [1:0] {
    MODE_DEC = 2'd0,
    MODE_HEX = 2'd1,
    MODE_BIN = 2'd2
  } mode_e;

  localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;
  // Largest accumulator that still takes one more decimal digit: (2^63 - d) / 10.
  localparam logic [63:0] DEC_LIMIT_LO = 64'd922337203685477580;
  localparam logic [63:0] DEC_LIMIT_NINE = 64'd922337203685477579;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_ONE = 8'h31;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_F = 8'h66;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_F = 8'h46;
  localparam logic [7:0] CH_LO_X = 8'h78;
  localparam logic [7:0] CH_UP_X = 8'h58;
  localparam logic [7:0] CH_LO_B = 8'h62;
  localparam logic [7:0] CH_UP_B = 8'h42;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_t;

  typedef struct packed {
    logic        is_number;
    logic [63:0] value;
    logic [1:0]  radix;
    logic        overflow;
  } out_t;

  // Parser state at the close of a token.
  typedef struct packed {
    mode_e       mode;
    logic        still_valid;
    logic        seen_digit;
    logic        negative;
    logic        overflowed;
    logic [63:0] acc;
  } snap_t;

  // Returns {valid, nibble} for a hexadecimal digit character.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = {1'b1, c[3:0]};
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      r = {1'b1, c[3:0] + 4'd9};
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ===== design/ilr_step.sv =====
// Per-character parser: holds the token state and updates it once per request.
// Depends on ilr_pkg.
module ilr_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  ilr_pkg::in_t  item_i,
  output logic          snap_valid_o,
  output ilr_pkg::snap_t snap_o
);
  import ilr_pkg::*;

  logic [1:0]  pos_q, pos_d;
  mode_e       mode_q, mode_d;
  logic        fiz_q, fiz_d;
  logic        neg_q, neg_d;
  logic        sv_q, sv_d;
  logic        seen_q, seen_d;
  logic [63:0] acc_q, acc_d;
  logic        ovf_q, ovf_d;

  logic        is_dig;
  logic [63:0] dig;
  logic [63:0] dec_limit;
  logic        dec_sv, dec_seen, dec_ovf;
  logic [63:0] dec_acc;
  logic [4:0]  hv;
  logic        is_bin;
  logic        is_x, is_b;

  // Decimal digit step, shared by the first character and the decimal mode.
  always_comb begin
    is_dig = (item_i.ch >= CH_ZERO) && (item_i.ch <= CH_NINE);
    dig = {60'd0, item_i.ch[3:0]};
    dec_limit = (item_i.ch == CH_NINE) ? DEC_LIMIT_NINE : DEC_LIMIT_LO;
    dec_sv = sv_q;
    dec_seen = seen_q;
    dec_ovf = ovf_q;
    dec_acc = acc_q;
    if (!is_dig) begin
      dec_sv = 1'b0;
    end else begin
      dec_seen = 1'b1;
      if (!ovf_q) begin
        if (acc_q > dec_limit) begin
          dec_ovf = 1'b1;
        end else begin
          dec_acc = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0} + dig;
        end
      end
    end
  end

  always_comb begin
    hv = hex_val(item_i.ch);
    is_bin = (item_i.ch == CH_ZERO) || (item_i.ch == CH_ONE);
    is_x = (item_i.ch == CH_LO_X) || (item_i.ch == CH_UP_X);
    is_b = (item_i.ch == CH_LO_B) || (item_i.ch == CH_UP_B);

    pos_d = pos_q;
    mode_d = mode_q;
    fiz_d = fiz_q;
    neg_d = neg_q;
    sv_d = sv_q;
    seen_d = seen_q;
    acc_d = acc_q;
    ovf_d = ovf_q;

    if (pos_q == 2'd0) begin
      fiz_d = (item_i.ch == CH_ZERO);
      if (item_i.ch == CH_PLUS || item_i.ch == CH_MINUS) begin
        neg_d = (item_i.ch == CH_MINUS);
      end else begin
        sv_d = dec_sv;
        seen_d = dec_seen;
        ovf_d = dec_ovf;
        acc_d = dec_acc;
      end
    end else if (pos_q == 2'd1 && !item_i.last && is_x) begin
      mode_d = MODE_HEX;
      sv_d = fiz_q;
      acc_d = '0;
    end else if (pos_q == 2'd1 && !item_i.last && is_b) begin
      mode_d = MODE_BIN;
      sv_d = fiz_q;
      acc_d = '0;
    end else begin
      case (mode_q)
        MODE_HEX: begin
          if (hv[4]) begin
            acc_d = {acc_q[59:0], hv[3:0]};
          end else begin
            sv_d = 1'b0;
          end
        end
        MODE_BIN: begin
          if (is_bin) begin
            acc_d = {acc_q[62:0], item_i.ch[0]};
          end else begin
            sv_d = 1'b0;
          end
        end
        default: begin
          sv_d = dec_sv;
          seen_d = dec_seen;
          ovf_d = dec_ovf;
          acc_d = dec_acc;
        end
      endcase
    end
    if (pos_q != 2'd3) begin
      pos_d = pos_q + 2'd1;
    end

    snap_o.mode = mode_d;
    snap_o.still_valid = sv_d;
    snap_o.seen_digit = seen_d;
    snap_o.negative = neg_d;
    snap_o.overflowed = ovf_d;
    snap_o.acc = acc_d;
    snap_valid_o = fire_i && item_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 2'd0;
      mode_q <= MODE_DEC;
      fiz_q <= 1'b0;
      neg_q <= 1'b0;
      sv_q <= 1'b1;
      seen_q <= 1'b0;
      acc_q <= '0;
      ovf_q <= 1'b0;
    end else if (fire_i) begin
      if (item_i.last) begin
        // The token is closed: start the next one from a clean state.
        pos_q <= 2'd0;
        mode_q <= MODE_DEC;
        fiz_q <= 1'b0;
        neg_q <= 1'b0;
        sv_q <= 1'b1;
        seen_q <= 1'b0;
        acc_q <= '0;
        ovf_q <= 1'b0;
      end else begin
        pos_q <= pos_d;
        mode_q <= mode_d;
        fiz_q <= fiz_d;
        neg_q <= neg_d;
        sv_q <= sv_d;
        seen_q <= seen_d;
        acc_q <= acc_d;
        ovf_q <= ovf_d;
      end
    end
  end

endmodule

// ===== design/ilr_finish.sv =====
// Result formatting: validity, decimal range check and sign for a closed token.
// Depends on ilr_pkg.
module ilr_finish (
  input  ilr_pkg::snap_t snap_i,
  output ilr_pkg::out_t  res_o
);
  import ilr_pkg::*;

  logic ok;

  always_comb begin
    res_o.value = '0;
    res_o.overflow = 1'b0;
    res_o.radix = snap_i.mode;
    case (snap_i.mode)
      MODE_HEX, MODE_BIN: begin
        ok = snap_i.still_valid;
        if (ok) begin
          res_o.value = snap_i.acc;
        end
      end
      default: begin
        ok = snap_i.still_valid && snap_i.seen_digit;
        if (ok) begin
          // A positive magnitude of exactly 2^63 does not fit either.
          if (snap_i.overflowed || (!snap_i.negative && snap_i.acc == MAG_LIMIT)) begin
            res_o.overflow = 1'b1;
          end else if (snap_i.negative) begin
            res_o.value = 64'd0 - snap_i.acc;
          end else begin
            res_o.value = snap_i.acc;
          end
        end
      end
    endcase
    res_o.is_number = ok;
  end

endmodule

// ===== design/integer_literal_recognizer_top.sv =====
// Integer literal recognizer, top level. Takes one token character per request
// and gives one result per token. Accepts a character in every cycle unless the
// pipeline stalls; the token state is updated once per accepted character. After
// its last character, a token's result moves from the input register through the
// token snapshot register to the result register, and a stalled result holds the
// pipeline behind it only once every stage is full.
// Depends on ilr_pkg, ilr_step, ilr_finish and the assertion macro header.
`include "integer_literal_recognizer_top_macros.svh"
module integer_literal_recognizer_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ilr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ilr_pkg::out_t out_data_o
);
  import ilr_pkg::*;

  in_t   in_q;
  logic  in_valid_q;
  snap_t snap_q;
  logic  snap_valid_q;
  out_t  out_q;
  logic  out_valid_q;

  logic  out_ready, snap_ready, in_ready, in_fire, step_fire;
  logic  snap_valid;
  snap_t snap;
  out_t  res;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign snap_ready = !snap_valid_q || out_ready;
  assign step_fire = in_valid_q && snap_ready;
  assign in_ready = !in_valid_q || snap_ready;
  assign in_fire = in_valid_i && in_ready;
  assign in_stall_o = !in_ready;

  ilr_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (step_fire),
    .item_i       (in_q),
    .snap_valid_o (snap_valid),
    .snap_o       (snap)
  );

  ilr_finish u_finish (
    .snap_i (snap_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      snap_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_fire;
      end
      if (snap_ready) begin
        snap_valid_q <= snap_valid;
      end
      if (out_ready) begin
        out_valid_q <= snap_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_data_i;
    end
    if (snap_ready && snap_valid) begin
      snap_q <= snap;
    end
    if (out_ready && snap_valid_q) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  `ILR_ASSERT_IMPL(a_invalid_is_zero, out_valid_q && !out_q.is_number,
                   out_q.value == 64'd0 && !out_q.overflow,
                   "invalid token reports a nonzero value or overflow")
  `ILR_ASSERT_IMPL(a_overflow_decimal, out_valid_q && out_q.overflow,
                   out_q.radix == MODE_DEC && out_q.value == 64'd0,
                   "overflow on a non-decimal token or with a value")
  `ILR_ASSERT_NEXT(a_in_reg_held, in_valid_q && !step_fire,
                   in_valid_q && $stable(in_q),
                   "pending character lost from the input register")
  `ILR_ASSERT_NEXT(a_snap_held, snap_valid_q && !out_ready,
                   snap_valid_q && $stable(snap_q),
                   "closed token lost before its result was formed")

endmodule
